>>> rtl/dfbrw_pkg.sv
package dfbrw_pkg;

  // walk bounds and feedback delay
  localparam int unsigned HalfRange = 50;
  localparam int unsigned DelayA    = 50;

  // field widths
  localparam int unsigned ValW  = 7;
  localparam int unsigned CfgW  = 6;
  localparam int unsigned RandW = 32;

  // derived widths
  localparam int unsigned PosW  = (DelayA > 1) ? $clog2(DelayA) : 1;
  localparam int unsigned KW    = CfgW + 1;
  localparam int unsigned HkW   = $clog2(HalfRange * HalfRange + 1);
  localparam int unsigned CoefW = $clog2(200 * HalfRange * HalfRange + 1);
  localparam int unsigned SumW  = $clog2(199 * HalfRange * HalfRange + 1);
  localparam int unsigned CmpW  = (CoefW > SumW) ? CoefW : SumW;
  localparam int unsigned ProdW = RandW + CoefW;

  localparam logic [PosW-1:0] LastPos = PosW'(DelayA - 1);
  localparam logic [CfgW-1:0] MaxD    = CfgW'(HalfRange - 1);

  typedef logic signed [ValW-1:0] val_t;

  localparam val_t ResetValue = val_t'(1);

  // feedback settings derived at configuration write
  typedef struct packed {
    logic [CfgW-1:0]  dclamp;
    logic [HkW-1:0]   hk;
    logic [CoefW-1:0] coef;
  } cfg_t;

endpackage

>>> rtl/delayed_feedback_bounded_random_walk.sv
// channel   dir  width  beat contents
// s_axis    in   32     tdata[31:0] random_word
// m_axis    out  8      tdata[6:0] walk_value, tdata[7] stepped_up
// cfg       in   6      cfg_wdata feedback_width, written when cfg_we is high
//
// each beat first does the history memory read and the random word scaling
// multiply, then the feedback compare and the read-modify-write of the
// present value and history ring.
// reset clears the history valid bits at once, so no clearing pass is needed.
// a new input beat is taken while a result still waits; the compare and
// write-back step holds until the output register is free.
module delayed_feedback_bounded_random_walk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [31:0]                 s_axis_tdata_i,   // [31:0] random_word
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,   // [6:0] walk_value, [7] stepped_up
  input  logic                        cfg_we_i,
  input  logic [dfbrw_pkg::CfgW-1:0]  cfg_wdata_i
);

  typedef enum logic {
    StIdle,
    StCalc
  } state_e;

  state_e                       state_q;
  dfbrw_pkg::val_t              present_q, present_d;
  dfbrw_pkg::val_t              out_val_q;
  dfbrw_pkg::val_t              past;
  logic                         out_up_q, out_valid_q;
  logic [dfbrw_pkg::PosW-1:0]   pos_q;
  logic                         accept, finish, up;
  logic signed [dfbrw_pkg::ValW:0] nx, hmax;
  dfbrw_pkg::cfg_t              cfg;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign finish = (state_q == StCalc) && (!out_valid_q || m_axis_tready_i);

  dfbrw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  dfbrw_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .wr_en_i (finish),
    .addr_i  (pos_q),
    .wdata_i (present_q),
    .rdata_o (past)
  );

  dfbrw_step u_step (
    .clk_i         (clk_i),
    .start_i       (accept),
    .random_word_i (s_axis_tdata_i),
    .cfg_i         (cfg),
    .past_i        (past),
    .present_i     (present_q),
    .up_o          (up)
  );

  // step one unit and clamp to the range
  assign hmax = signed'((dfbrw_pkg::ValW + 1)'(dfbrw_pkg::HalfRange));
  always_comb begin
    nx = (dfbrw_pkg::ValW + 1)'(present_q) + (up ? 8'sd1 : -8'sd1);
    if (nx > hmax) begin
      nx = hmax;
    end
    if (nx < -hmax) begin
      nx = -hmax;
    end
    present_d = dfbrw_pkg::val_t'(nx[dfbrw_pkg::ValW-1:0]);
  end

  // sequencer, walk state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      present_q   <= dfbrw_pkg::ResetValue;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_up_q    <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StCalc;
          end
        end
        StCalc: begin
          if (finish) begin
            state_q     <= StIdle;
            present_q   <= present_d;
            pos_q       <= (pos_q == dfbrw_pkg::LastPos) ? '0 : pos_q + 1'b1;
            out_val_q   <= present_d;
            out_up_q    <= up;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_up_q, out_val_q};

endmodule

>>> rtl/dfbrw_cfg.sv
module dfbrw_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [dfbrw_pkg::CfgW-1:0] wdata_i,
  output dfbrw_pkg::cfg_t            cfg_o
);

  logic [dfbrw_pkg::CfgW-1:0] d_clamped;
  logic [dfbrw_pkg::KW-1:0]   k;
  dfbrw_pkg::cfg_t            cfg_d, cfg_q;

  // clamp the threshold so that the band never covers the whole range
  assign d_clamped = (wdata_i > dfbrw_pkg::MaxD) ? dfbrw_pkg::MaxD : wdata_i;
  assign k = dfbrw_pkg::KW'(dfbrw_pkg::HalfRange) - {1'b0, d_clamped};

  always_comb begin
    cfg_d.dclamp = d_clamped;
    cfg_d.hk     = dfbrw_pkg::HkW'(dfbrw_pkg::HalfRange * k);
    cfg_d.coef   = dfbrw_pkg::CoefW'(200 * dfbrw_pkg::HalfRange * k);
  end

  // settings register, reset to a zero threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dclamp <= '0;
      cfg_q.hk     <= dfbrw_pkg::HkW'(dfbrw_pkg::HalfRange * dfbrw_pkg::HalfRange);
      cfg_q.coef   <= dfbrw_pkg::CoefW'(200 * dfbrw_pkg::HalfRange * dfbrw_pkg::HalfRange);
    end else if (we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/dfbrw_hist.sv
module dfbrw_hist (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic                       wr_en_i,
  input  logic [dfbrw_pkg::PosW-1:0] addr_i,
  input  dfbrw_pkg::val_t            wdata_i,
  output dfbrw_pkg::val_t            rdata_o
);

  dfbrw_pkg::val_t                 mem_q [dfbrw_pkg::DelayA];
  dfbrw_pkg::val_t                 rdata_q;
  logic [dfbrw_pkg::DelayA-1:0]    valid_q;
  logic                            rvalid_q;

  // history ring storage with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // per-entry valid bits, an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

>>> rtl/dfbrw_step.sv
module dfbrw_step (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic [dfbrw_pkg::RandW-1:0] random_word_i,
  input  dfbrw_pkg::cfg_t             cfg_i,
  input  dfbrw_pkg::val_t             past_i,
  input  dfbrw_pkg::val_t             present_i,
  output logic                        up_o
);

  localparam int unsigned XW = dfbrw_pkg::ValW + 2;

  logic [dfbrw_pkg::ProdW-1:0] prod;
  logic [dfbrw_pkg::CoefW-1:0] prod_hi_q;
  logic signed [XW-1:0]        a_x, b_x, d_x, h_x, ha, hb;
  logic [dfbrw_pkg::HkW-1:0]   fa, fb;
  logic [dfbrw_pkg::SumW-1:0]  sum;

  // first step: scale the random word, keep only the part above 2^32
  assign prod = {{dfbrw_pkg::CoefW{1'b0}}, random_word_i}
              * {{dfbrw_pkg::RandW{1'b0}}, cfg_i.coef};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_hi_q <= prod[dfbrw_pkg::ProdW-1:dfbrw_pkg::RandW];
    end
  end

  // second step: feedback terms from the delayed and present values
  assign a_x = XW'(past_i);
  assign b_x = XW'(present_i);
  assign d_x = signed'(XW'(cfg_i.dclamp));
  assign h_x = signed'(XW'(dfbrw_pkg::HalfRange));
  assign ha  = h_x - a_x;
  assign hb  = h_x + b_x;

  assign fa = (a_x <= d_x) ? cfg_i.hk
                           : dfbrw_pkg::HkW'(dfbrw_pkg::HalfRange * unsigned'(ha));
  assign fb = (b_x >= -d_x) ? cfg_i.hk
                            : dfbrw_pkg::HkW'(dfbrw_pkg::HalfRange * unsigned'(hb));

  // threshold stays positive since both terms lie within 0..hk
  assign sum = dfbrw_pkg::SumW'(100 * cfg_i.hk) + dfbrw_pkg::SumW'(99 * fa)
             - dfbrw_pkg::SumW'(99 * fb);

  assign up_o = dfbrw_pkg::CmpW'(prod_hi_q) < dfbrw_pkg::CmpW'(sum);

endmodule
